// ===== sv/gem_pkg.sv =====
// gem_pkg: shared constants, register codes and the window type for the
// gradient edge magnitude block. Used by every module of the block.
// No dependencies.
package gem_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W = 8;
	localparam int ROW_W = 12;
	localparam int OUT_COL_W = 10;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int CW_W = 8;
	localparam int LB_W = 2 * PIX_W;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd2;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [CW_W-1:0] CENTER_WEIGHT_RST = 8'd16;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// 3x3 window taps, row then column; column 0 is the oldest
	typedef struct packed {
		logic [PIX_W-1:0] a00;
		logic [PIX_W-1:0] a10;
		logic [PIX_W-1:0] a20;
		logic [PIX_W-1:0] a01;
		logic [PIX_W-1:0] a21;
		logic [PIX_W-1:0] a02;
		logic [PIX_W-1:0] a12;
		logic [PIX_W-1:0] a22;
	} win_t;

endpackage

// ===== sv/gem_line_buf.sv =====
// gem_line_buf: two line buffers packed in one memory word {older, newer},
// one read and one write per cycle, registered read with write forwarding.
// Depends on gem_pkg.
module gem_line_buf #(
	parameter int Depth = gem_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [$clog2(Depth)-1:0]  rd_addr,
	input  logic                      wr_en,
	input  logic [$clog2(Depth)-1:0]  wr_addr,
	input  logic [gem_pkg::LB_W-1:0]  wr_data,
	output logic [gem_pkg::LB_W-1:0]  rd_data
);

	logic [gem_pkg::LB_W-1:0] mem [Depth];
	logic [gem_pkg::LB_W-1:0] ram_q;
	logic [gem_pkg::LB_W-1:0] byp_q;
	logic                     byp_sel_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q <= mem[rd_addr];
			byp_q <= wr_data;
		end
	end

	// forward the word written in the same cycle as a read of its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_sel_q <= 1'b0;
		end else if (rd_en) begin
			byp_sel_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_sel_q ? byp_q : ram_q;

endmodule

// ===== sv/gem_grad.sv =====
// gem_grad: vertical and horizontal gradients of one 3x3 window with a
// Q4.4 center weight, clamped absolute values and saturated sum.
// Depends on gem_pkg.
module gem_grad (
	input  gem_pkg::win_t                win,
	input  logic [gem_pkg::CW_W-1:0]     weight,
	output logic [gem_pkg::PIX_W-1:0]    mag
);

	localparam int PW = gem_pkg::PIX_W + gem_pkg::CW_W;
	localparam int SW = PW - 4;
	localparam int GW = SW + 2;

	logic [PW-1:0] p21, p01, p12, p10;
	logic [GW-1:0] v_pos, v_neg, h_pos, h_neg;
	logic signed [GW-1:0] gv, gh;
	logic [GW-1:0] av, ah;
	logic [gem_pkg::PIX_W-1:0] cv, ch;
	logic [gem_pkg::PIX_W:0] sum;

	always_comb begin
		p21 = PW'(win.a21) * PW'(weight);
		p01 = PW'(win.a01) * PW'(weight);
		p12 = PW'(win.a12) * PW'(weight);
		p10 = PW'(win.a10) * PW'(weight);

		v_pos = GW'(win.a20) + GW'(p21[PW-1:4]) + GW'(win.a22);
		v_neg = GW'(win.a00) + GW'(p01[PW-1:4]) + GW'(win.a02);
		h_pos = GW'(win.a02) + GW'(p12[PW-1:4]) + GW'(win.a22);
		h_neg = GW'(win.a00) + GW'(p10[PW-1:4]) + GW'(win.a20);

		gv = $signed(v_pos) - $signed(v_neg);
		gh = $signed(h_pos) - $signed(h_neg);
		av = gv[GW-1] ? GW'(-gv) : GW'(gv);
		ah = gh[GW-1] ? GW'(-gh) : GW'(gh);

		cv = (av > GW'(gem_pkg::PIX_MAX)) ? gem_pkg::PIX_MAX : av[gem_pkg::PIX_W-1:0];
		ch = (ah > GW'(gem_pkg::PIX_MAX)) ? gem_pkg::PIX_MAX : ah[gem_pkg::PIX_W-1:0];

		sum = {1'b0, cv} + {1'b0, ch};
		mag = sum[gem_pkg::PIX_W] ? gem_pkg::PIX_MAX : sum[gem_pkg::PIX_W-1:0];
	end

endmodule

// ===== sv/gradient_edge_magnitude_3x3.sv =====
// gradient_edge_magnitude_3x3: streaming 3x3 edge magnitude filter, top level.
// Depends on gem_pkg, gem_line_buf and gem_grad.
//
// Pixels enter in raster order on pixel/frame_start, one word per clock,
// qualified by in_valid and held off by in_stall. frame_start on a word
// restarts the row and column count at row 0, column 0; without it the
// counters wrap at the clamped width (3..MAX_WIDTH) and height (3..4096).
// A result word (magnitude, out_row, out_col, frame_last) leaves on
// out_valid for every pixel that completes an interior window; border
// positions give no word. frame_last marks the window of the last row and
// column of the frame.
// Throughput: one pixel per clock, sustained while out_stall is low; the
// line buffer memory does one read and one write per cycle. Each accepted
// pixel is registered in the input stage, where its window and gradients
// are formed; a pixel that completes a window loads the result register.
// When out_stall and out_valid are high, the result register holds; border
// pixels keep passing, and once a pixel that completes a window waits in the
// input stage, in_stall rises in that same cycle. Reset clears the counters,
// window and valid bits and sets width 640, height 480 and center weight 1.0.
// Line buffer contents are undefined until the first two rows of a frame have
// passed. Configuration is written through cfg_we/cfg_index/cfg_data only
// by the user while no pixel is in flight; the block does not enforce it.
module gradient_edge_magnitude_3x3 #(
	parameter int MAX_WIDTH = gem_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gem_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gem_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [gem_pkg::PIX_W-1:0]         pixel,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [gem_pkg::PIX_W-1:0]         magnitude,
	output logic [gem_pkg::ROW_W-1:0]         out_row,
	output logic [gem_pkg::OUT_COL_W-1:0]     out_col,
	output logic                              frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CNTW = CW + 1;
	localparam int XW = (CNTW > gem_pkg::FW_W) ? CNTW : gem_pkg::FW_W;
	localparam int PW = gem_pkg::PIX_W;
	localparam int RW = gem_pkg::ROW_W;
	localparam int HW = gem_pkg::FH_W;

	// configuration
	logic [gem_pkg::FW_W-1:0] frame_width_q;
	logic [HW-1:0]            frame_height_q;
	logic [gem_pkg::CW_W-1:0] center_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= gem_pkg::FRAME_WIDTH_RST;
			frame_height_q <= gem_pkg::FRAME_HEIGHT_RST;
			center_weight_q <= gem_pkg::CENTER_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gem_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data[gem_pkg::FW_W-1:0];
				gem_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[HW-1:0];
				gem_pkg::REG_CENTER_WEIGHT: center_weight_q <= cfg_data[gem_pkg::CW_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped frame size
	logic [XW-1:0]   fw_x, w_x;
	logic [CNTW-1:0] w_c;
	logic [HW-1:0]   h_c;

	always_comb begin
		fw_x = XW'(frame_width_q);
		if (fw_x < XW'(3)) begin
			w_x = XW'(3);
		end else if (fw_x > XW'(MAX_WIDTH)) begin
			w_x = XW'(MAX_WIDTH);
		end else begin
			w_x = fw_x;
		end
		w_c = CNTW'(w_x);
		if (frame_height_q < HW'(3)) begin
			h_c = HW'(3);
		end else if (frame_height_q > HW'(gem_pkg::MAX_HEIGHT)) begin
			h_c = HW'(gem_pkg::MAX_HEIGHT);
		end else begin
			h_c = frame_height_q;
		end
	end

	// handshake and pipeline control
	logic          in_acc;
	logic          s1_valid_q;
	logic          s1_emit;
	logic          s1_adv;
	logic          s2_free;
	logic          out_valid_q;

	logic [PW-1:0] px_s1;
	logic [CW-1:0] c_s1;
	logic [RW-1:0] r_s1;

	assign s2_free = !out_valid_q || !out_stall;
	assign s1_emit = (r_s1 >= RW'(2)) && (c_s1 >= CW'(2));
	assign s1_adv = s1_valid_q && (!s1_emit || s2_free);
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_acc = in_valid && !in_stall;

	// position counters
	logic [CW-1:0] col_q, c_now;
	logic [RW-1:0] row_q, r_now;
	logic [CNTW-1:0] c_inc;
	logic [HW-1:0]   r_inc;

	always_comb begin
		c_now = frame_start ? '0 : col_q;
		r_now = frame_start ? '0 : row_q;
		c_inc = {1'b0, c_now} + CNTW'(1);
		r_inc = {1'b0, r_now} + HW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (c_inc >= w_c) begin
				col_q <= '0;
				row_q <= (r_inc >= h_c) ? '0 : r_inc[RW-1:0];
			end else begin
				col_q <= c_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1 <= pixel;
			c_s1 <= c_now;
			r_s1 <= r_now;
		end
	end

	// line buffers: word is {two rows above, one row above}
	logic [gem_pkg::LB_W-1:0] lb_rd;
	logic [PW-1:0]            top, mid;

	assign top = lb_rd[gem_pkg::LB_W-1:PW];
	assign mid = lb_rd[PW-1:0];

	gem_line_buf #(
		.Depth(MAX_WIDTH)
	) u_line_buf (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(in_acc),
		.rd_addr(c_now),
		.wr_en(s1_adv),
		.wr_addr(c_s1),
		.wr_data({mid, px_s1}),
		.rd_data(lb_rd)
	);

	// window columns: 0..2 oldest, 3..5 previous (top, mid, bottom)
	logic [PW-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= px_s1;
		end
	end

	gem_pkg::win_t win;
	logic [PW-1:0] mag_s1;
	logic          last_s1;

	always_comb begin
		win.a00 = win_q[0];
		win.a10 = win_q[1];
		win.a20 = win_q[2];
		win.a01 = win_q[3];
		win.a21 = win_q[5];
		win.a02 = top;
		win.a12 = mid;
		win.a22 = px_s1;
		last_s1 = ({1'b0, r_s1} == h_c - HW'(1)) && ({1'b0, c_s1} == w_c - CNTW'(1));
	end

	gem_grad u_grad (
		.win(win),
		.weight(center_weight_q),
		.mag(mag_s1)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_free) begin
			out_valid_q <= s1_adv && s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && s1_emit) begin
			magnitude <= mag_s1;
			out_row <= r_s1 - RW'(1);
			out_col <= gem_pkg::OUT_COL_W'(c_s1 - CW'(1));
			frame_last <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && s1_emit && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_adv && s1_emit && out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_interior_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_row != '0)
		else $error("border row emitted");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for gradient_edge_magnitude_3x3, with its own
// line-buffer predictor, random stalls on both sides and a result scoreboard.
// Depends on gem_pkg and the gradient_edge_magnitude_3x3 RTL.
module tb;

	localparam int PIX_W = gem_pkg::PIX_W;
	localparam int ROW_W = gem_pkg::ROW_W;
	localparam int OUT_COL_W = gem_pkg::OUT_COL_W;
	localparam int FW_W = gem_pkg::FW_W;
	localparam int FH_W = gem_pkg::FH_W;
	localparam int CW_W = gem_pkg::CW_W;
	localparam int CFG_IDX_W = gem_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gem_pkg::CFG_DATA_W;

	localparam int MAX_W = gem_pkg::MAX_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 220;
	localparam int SETTLE = 6;
	localparam int TAIL = 10;
	localparam int LIMIT = 2000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [PIX_W-1:0] mag;
		logic [ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic last;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] pixel = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] magnitude;
	logic [ROW_W-1:0] out_row;
	logic [OUT_COL_W-1:0] out_col;
	logic frame_last;

	// predictor state and register copies
	logic [FW_W-1:0] cfg_width = gem_pkg::FRAME_WIDTH_RST;
	logic [FH_W-1:0] cfg_height = gem_pkg::FRAME_HEIGHT_RST;
	logic [CW_W-1:0] cfg_weight = gem_pkg::CENTER_WEIGHT_RST;
	logic [PIX_W-1:0] row_above [MAX_W];
	logic [PIX_W-1:0] row_above2 [MAX_W];
	logic [PIX_W-1:0] win_taps [6];
	int col_pos = 0;
	int row_pos = 0;

	edge_result_t expected_results [$];
	edge_result_t head_result;
	int errors = 0;
	int pixels_sent = 0;
	int cycles = 0;
	int hold_off = 0;
	int stall_left = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	gradient_edge_magnitude_3x3 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.magnitude(magnitude),
		.out_row(out_row),
		.out_col(out_col),
		.frame_last(frame_last)
	);

	always #2 clk = ~clk;

	initial begin
		foreach (row_above[i]) begin
			row_above[i] = '0;
			row_above2[i] = '0;
		end
		foreach (win_taps[i]) win_taps[i] = '0;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int center_term(input logic [PIX_W-1:0] p);
		return (int'(p) * int'(cfg_weight)) >> 4;
	endfunction

	function automatic int abs_sat(input int g);
		int m;
		m = (g < 0) ? -g : g;
		return (m > 255) ? 255 : m;
	endfunction

	function automatic void predict_pixel(input logic [PIX_W-1:0] px, input logic fs);
		int w, h, c, r, gv, gh, mag;
		logic [PIX_W-1:0] top, mid;
		edge_result_t res;
		w = clamp_int(int'(cfg_width), 3, MAX_W);
		h = clamp_int(int'(cfg_height), 3, gem_pkg::MAX_HEIGHT);
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		top = row_above2[c];
		mid = row_above[c];
		if (r >= 2 && c >= 2) begin
			gv = (int'(win_taps[2]) + center_term(win_taps[5]) + int'(px))
				- (int'(win_taps[0]) + center_term(win_taps[3]) + int'(top));
			gh = (int'(top) + center_term(mid) + int'(px))
				- (int'(win_taps[0]) + center_term(win_taps[1]) + int'(win_taps[2]));
			mag = abs_sat(gv) + abs_sat(gh);
			if (mag > 255) mag = 255;
			res.mag = 8'(mag);
			res.row = 12'(r - 1);
			res.col = 10'(c - 1);
			res.last = (r == h - 1) && (c == w - 1);
			expected_results.insert(expected_results.size(), res);
		end
		row_above2[c] = mid;
		row_above[c] = px;
		win_taps[0] = win_taps[3];
		win_taps[1] = win_taps[4];
		win_taps[2] = win_taps[5];
		win_taps[3] = top;
		win_taps[4] = mid;
		win_taps[5] = px;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	// mostly zero, some short runs, a few long ones
	function automatic int draw_run();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) return 0;
		if (pick < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PIX_W-1:0] next_pixel(input int style);
		if (style == 0) return $urandom_range(0, 1) ? gem_pkg::PIX_MAX : '0;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return gem_pkg::PIX_MAX;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			gem_pkg::REG_FRAME_WIDTH: cfg_width = FW_W'(value);
			gem_pkg::REG_FRAME_HEIGHT: cfg_height = FH_W'(value);
			gem_pkg::REG_CENTER_WEIGHT: cfg_weight = CW_W'(value);
			default: ;
		endcase
	endtask

	task automatic program_frame(input int w, input int h, input int wt);
		write_reg(gem_pkg::REG_FRAME_WIDTH, w);
		write_reg(gem_pkg::REG_FRAME_HEIGHT, h);
		write_reg(gem_pkg::REG_CENTER_WEIGHT, wt);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
		int gap;
		gap = tx_quiet ? 0 : draw_run();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		pixel = px;
		frame_start = fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_pixel(px, fs);
		pixels_sent++;
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		wait_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		// row 0 of the default 640-wide frame gives no word
		tx_quiet = 1'b1;
		for (int i = 0; i < 24; i++) send_pixel(next_pixel(1), 1'b0);
		tx_quiet = 1'b0;
		wait_idle();
		// keep the reset center weight
		write_reg(gem_pkg::REG_FRAME_WIDTH, 4);
		write_reg(gem_pkg::REG_FRAME_HEIGHT, 4);
		for (int i = 0; i < 16; i++) send_pixel(next_pixel(2), i == 0);
		wait_idle();
	endtask

	task automatic test_directed_extremes();
		// sizes below the minimum clamp to 3x3; the unused index is ignored
		program_frame(0, 2, 255);
		write_reg(REG_UNUSED, 13'h1FFF);
		for (int i = 0; i < 9; i++) send_pixel((i >= 6) ? gem_pkg::PIX_MAX : '0, i == 0);
		// next frame back to back without frame_start
		for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? gem_pkg::PIX_MAX : '0, 1'b0);
		// restart in the middle of a frame
		send_pixel(gem_pkg::PIX_MAX, 1'b1);
		send_pixel(gem_pkg::PIX_MAX, 1'b0);
		for (int i = 0; i < 9; i++) send_pixel((i % 2) ? gem_pkg::PIX_MAX : '0, i == 0);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int target, phase, w, h, wt, wu, hu, frames, kind, len, style;
		logic fs;
		target = pixels_sent + RANDOM_ITEMS;
		phase = 0;
		while (pixels_sent < target) begin
			wait_idle();
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
			case (phase % 5)
				0: wt = 16;
				1: wt = 32;
				2: wt = 0;
				3: wt = 255;
				default: wt = $urandom_range(0, 255);
			endcase
			program_frame(w, h, wt);
			wu = clamp_int(w, 3, MAX_W);
			hu = clamp_int(h, 3, gem_pkg::MAX_HEIGHT);
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				kind = (f == 0) ? 0 : $urandom_range(0, 9);
				style = $urandom_range(0, 3);
				len = (kind == 9) ? $urandom_range(1, wu * hu - 1) : wu * hu;
				for (int i = 0; i < len; i++) begin
					case (kind)
						6, 7: fs = 1'b0;
						8: fs = (i == 0) || ($urandom_range(0, 15) == 0);
						default: fs = (i == 0);
					endcase
					send_pixel(next_pixel(style), fs);
				end
			end
			phase++;
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		program_frame(8, 6, 32);
		@(posedge clk);
		hold_off = 150;
		tx_quiet = 1'b1;
		for (int i = 0; i < 48; i++) send_pixel(next_pixel(1), i == 0);
		tx_quiet = 1'b0;
		wait_results();
		for (int i = 0; i < 48; i++) send_pixel(next_pixel(2), i == 0);
		wait_idle();
	endtask

	task automatic test_max_size();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		program_frame(2047, 3, 32);
		for (int i = 0; i < 12; i++) send_pixel(next_pixel(1), i == 0);
		wait_idle();
		program_frame(5, 8191, 200);
		for (int i = 0; i < 30; i++) send_pixel(next_pixel(0), i == 0);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		wait_idle();
	endtask

	// receiver stall
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_stall = 1'b1;
			hold_off = hold_off - 1;
		end else if (rx_quiet) begin
			out_stall = 1'b0;
		end else if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall = 1'b0;
			stall_left = draw_run();
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected, actual mag %0d row %0d col %0d",
					$time, magnitude, out_row, out_col);
			end else begin
				head_result = expected_results.pop_front();
				check_field("magnitude", head_result.mag, magnitude);
				check_field("out_row", head_result.row, out_row);
				check_field("out_col", head_result.col, out_col);
				check_field("frame_last", head_result.last, frame_last);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_directed_extremes();
		test_random_frames();
		test_backpressure();
		test_max_size();
		wait_idle();
		repeat (TAIL) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gem_pkg.sv
sv/gem_line_buf.sv
sv/gem_grad.sv
sv/gradient_edge_magnitude_3x3.sv
sim/tb.sv
